@@ design/bra_pkg.sv @@
// Shared types and constants for the bitmap register allocator.
// Field widths, operation and status codes, sequencer states, default sizes.
// No dependencies.
`default_nettype none

package bra_pkg;

  // Default sizes
  localparam int WORD_BITS_DEF   = 64;
  localparam int NUM_WORDS_DEF   = 4;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int MAX_RUN_DEF     = 32;

  // Item field widths
  localparam int OPCODE_W     = 3;
  localparam int RUN_LEN_W    = 6;
  localparam int STATUS_W     = 2;
  localparam int SLOT_W       = 8;
  localparam int HIGH_WATER_W = 9;
  localparam int DEPTH_W      = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC_ONE = 3'd0,
    OP_ALLOC_RUN = 3'd1,
    OP_SAVE      = 3'd2,
    OP_RESTORE   = 3'd3,
    OP_CLEAR     = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_ROOM     = 2'd1,
    ST_STACK_FULL  = 2'd2,
    ST_STACK_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GRANT,
    S_SAVE,
    S_LOAD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/bra_if.sv @@
// Valid/ready channel interfaces for the allocator's request and result items.
// Depends on bra_pkg for the field widths.
`default_nettype none

interface bra_in_if;
  import bra_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [RUN_LEN_W-1:0] run_length;

  modport source (output valid, opcode, run_length, input ready);
  modport sink   (input valid, opcode, run_length, output ready);
endinterface

interface bra_out_if;
  import bra_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_W-1:0]       slot_index;
  logic [HIGH_WATER_W-1:0] high_water;
  logic [DEPTH_W-1:0]      stack_depth;

  modport source (output valid, status, slot_index, high_water, stack_depth, input ready);
  modport sink   (input valid, status, slot_index, high_water, stack_depth, output ready);
endinterface

`default_nettype wire

@@ design/bra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the snapshot stack. No dependencies.
`default_nettype none

module bra_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/bra_run_unit.sv @@
// Run finder: lowest start of len consecutive free bits inside one word.
// Shared by both allocations (allocate one is a run of one). Uses bra_pkg.
`default_nettype none

module bra_run_unit #(
  parameter  int WORD_BITS = 64,
  localparam int LEN_W     = $clog2(WORD_BITS + 1),
  localparam int BI_W      = $clog2(WORD_BITS)
) (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [LEN_W-1:0]     len,
  output      logic                 found,
  output      logic [BI_W-1:0]      start
);
  import bra_pkg::*;

  localparam int LEVELS = $clog2(WORD_BITS) + 1;
  localparam int PW     = $clog2(LEVELS);

  // win[k][j]: bits j .. j+2^k-1 are all free (zeros shift in past the top)
  logic [WORD_BITS-1:0] win [LEVELS];
  logic [PW-1:0]        pow_sel;
  logic [LEN_W-1:0]     tail;
  logic [WORD_BITS-1:0] hits;

  assign win[0] = ~word;

  for (genvar k = 1; k < LEVELS; k++) begin : g_win
    assign win[k] = win[k-1] & (win[k-1] >> (1 << (k - 1)));
  end

  // Largest power of two not above len; two overlapping windows of that
  // size cover exactly len bits.
  always_comb begin
    pow_sel = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (len[i]) begin
        pow_sel = PW'(i);
      end
    end
  end

  assign tail = len - (LEN_W'(1) << pow_sel);
  assign hits = win[pow_sel] & (win[pow_sel] >> tail);

  always_comb begin
    start = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hits[j]) begin
        start = BI_W'(j);
      end
    end
  end

  assign found = |hits;

endmodule

`default_nettype wire

@@ design/bitmap_register_allocator_unit.sv @@
// Bitmap first-fit register allocator with snapshot stack: top level.
// Uses bra_pkg, bra_in_if / bra_out_if, bra_run_unit and bra_ram.
//
// Requests come in on in_ch (opcode, run_length), one result item per request
// leaves on out_ch (status, slot_index, high_water, stack_depth); both are
// valid/ready channels, an item moves when valid and ready are high at a clock.
// The block handles one request at a time: in_ch.ready is high only while idle.
// Steps from acceptance until the result is registered in out_ch:
//   allocate one / run : S_SCAN word by word, S_GRANT on a fit, then S_DONE; no room:
//                        all NUM_WORDS words scanned; a bad run length goes to S_DONE
//   save               : S_SAVE, one word written per cycle, then S_DONE
//   restore            : S_LOAD, one word read per cycle (registered read), then S_DONE
//   clear, other codes, full/empty stack : straight to S_DONE
// The scan examines one bitmap word per cycle through the run finder; save and
// restore are paced by the snapshot RAM ports. The next request is taken
// the cycle after the result is registered, even if that result is not taken.
// With the receiver stalled, a finished result waits in the sequencer until the
// output register frees up. Synchronous reset (rst_n low) empties the bitmap,
// the high-water mark and the stack count; snapshot RAM contents are not cleared.
`default_nettype none

module bitmap_register_allocator_unit #(
  parameter int WORD_BITS   = bra_pkg::WORD_BITS_DEF,
  parameter int NUM_WORDS   = bra_pkg::NUM_WORDS_DEF,
  parameter int STACK_DEPTH = bra_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RUN     = bra_pkg::MAX_RUN_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bra_in_if.sink    in_ch,
  bra_out_if.source out_ch
);
  import bra_pkg::*;

  localparam int LEN_W     = $clog2(WORD_BITS + 1);
  localparam int LEN_EXT_W = WORD_BITS + 1;
  localparam int BI_W      = $clog2(WORD_BITS);
  localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WC_W      = $clog2(NUM_WORDS + 1);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int MK_W      = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int RAM_DEPTH = STACK_DEPTH * NUM_WORDS;
  localparam int RA_W      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] occ_r [NUM_WORDS];
  logic [WORD_BITS-1:0] occ_nxt [NUM_WORDS];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MK_W-1:0]      mark_r, mark_nxt;
  logic [WC_W-1:0]      w_r, w_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [BI_W-1:0]      j_r, j_nxt;
  status_t              status_r, status_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic [HIGH_WATER_W-1:0] out_hw_r, out_hw_nxt;
  logic [DEPTH_W-1:0]      out_depth_r, out_depth_nxt;

  logic                 in_fire;
  logic                 len_ok;
  logic                 last_word;
  logic                 out_free;
  logic [WI_W-1:0]      wi;
  logic [WI_W-1:0]      wi_prev;
  logic                 run_found;
  logic [BI_W-1:0]      run_start;
  logic [LEN_EXT_W-1:0] ones_ext;
  logic [WORD_BITS-1:0] grant_mask;
  logic [31:0]          slot_full;
  logic [31:0]          end_full;
  logic                 ram_we;
  logic [RA_W-1:0]      ram_addr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign len_ok    = (in_ch.run_length != '0) && (32'(in_ch.run_length) <= MAX_RUN)
                     && (32'(in_ch.run_length) <= WORD_BITS);
  assign last_word = (w_r == WC_W'(NUM_WORDS - 1));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign wi        = w_r[WI_W-1:0];
  assign wi_prev   = WI_W'(w_r - WC_W'(1));

  bra_run_unit #(.WORD_BITS(WORD_BITS)) u_run (
    .word  (occ_r[wi]),
    .len   (len_r),
    .found (run_found),
    .start (run_start)
  );

  assign ones_ext   = (LEN_EXT_W'(1) << len_r) - LEN_EXT_W'(1);
  assign grant_mask = ones_ext[WORD_BITS-1:0] << j_r;
  assign slot_full  = 32'(w_r) * WORD_BITS + 32'(j_r);
  assign end_full   = slot_full + 32'(len_r);

  // Stack entry n occupies RAM words n*NUM_WORDS .. n*NUM_WORDS+NUM_WORDS-1
  assign ram_addr = RA_W'(32'(count_r) * NUM_WORDS + 32'(w_r));

  bra_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (occ_r[wi]),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (opcode_t'(in_ch.opcode))
            OP_ALLOC_ONE: state_nxt = S_SCAN;
            OP_ALLOC_RUN: state_nxt = len_ok ? S_SCAN : S_DONE;
            OP_SAVE:      state_nxt = (count_r >= CNT_W'(STACK_DEPTH)) ? S_DONE : S_SAVE;
            OP_RESTORE:   state_nxt = (count_r == '0) ? S_DONE : S_LOAD;
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (run_found) begin
          state_nxt = S_GRANT;
        end else if (last_word) begin
          state_nxt = S_DONE;
        end
      end
      S_GRANT: state_nxt = S_DONE;
      S_SAVE: begin
        if (last_word) begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        if (w_r == WC_W'(NUM_WORDS)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    occ_nxt        = occ_r;
    count_nxt      = count_r;
    mark_nxt       = mark_r;
    w_nxt          = w_r;
    len_nxt        = len_r;
    j_nxt          = j_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    ram_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_hw_nxt     = out_hw_r;
    out_depth_nxt  = out_depth_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          w_nxt      = '0;
          status_nxt = ST_OK;
          slot_nxt   = '0;
          case (opcode_t'(in_ch.opcode))
            OP_ALLOC_ONE: len_nxt = LEN_W'(1);
            OP_ALLOC_RUN: begin
              len_nxt = LEN_W'(in_ch.run_length);
              if (!len_ok) begin
                status_nxt = ST_NO_ROOM;
              end
            end
            OP_SAVE: begin
              if (count_r >= CNT_W'(STACK_DEPTH)) begin
                status_nxt = ST_STACK_FULL;
              end
            end
            OP_RESTORE: begin
              if (count_r == '0) begin
                status_nxt = ST_STACK_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < NUM_WORDS; i++) begin
                occ_nxt[i] = '0;
              end
              count_nxt = '0;
              mark_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (run_found) begin
          j_nxt = run_start;
        end else if (last_word) begin
          status_nxt = ST_NO_ROOM;
        end else begin
          w_nxt = w_r + WC_W'(1);
        end
      end
      S_GRANT: begin
        occ_nxt[wi] = occ_r[wi] | grant_mask;
        slot_nxt    = SLOT_W'(slot_full);
        if (end_full > 32'(mark_r)) begin
          mark_nxt = MK_W'(end_full);
        end
      end
      S_SAVE: begin
        ram_we = 1'b1;
        if (last_word) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          w_nxt = w_r + WC_W'(1);
        end
      end
      S_LOAD: begin
        // read issued for word w; the registered data lands in the next cycle, for word w-1
        if (w_r != '0) begin
          occ_nxt[wi_prev] = ram_rdata;
        end
        if (w_r != WC_W'(NUM_WORDS)) begin
          w_nxt = w_r + WC_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = slot_r;
          out_hw_nxt     = HIGH_WATER_W'(mark_r);
          out_depth_nxt  = DEPTH_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      mark_r      <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        occ_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      mark_r      <= mark_nxt;
      occ_r       <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    len_r        <= len_nxt;
    j_r          <= j_nxt;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hw_r     <= out_hw_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot_index  = out_slot_r;
  assign out_ch.high_water  = out_hw_r;
  assign out_ch.stack_depth = out_depth_r;

endmodule

`default_nettype wire

@@ design/bra_checker.sv @@
// Port-level assertions for bitmap_register_allocator_unit, bound to the top.
// Depends on bra_pkg and on the top level's channel ports.
`default_nettype none

module bra_checker #(
  parameter int STACK_DEPTH = bra_pkg::STACK_DEPTH_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [bra_pkg::STATUS_W-1:0]     out_status,
  input wire logic [bra_pkg::SLOT_W-1:0]       out_slot_index,
  input wire logic [bra_pkg::HIGH_WATER_W-1:0] out_high_water,
  input wire logic [bra_pkg::DEPTH_W-1:0]      out_stack_depth
);
  import bra_pkg::*;

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_slot_index) && $stable(out_high_water) && $stable(out_stack_depth))
    else $error("result changed while stalled");

  // One request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_STACK_FULL) |-> out_stack_depth == DEPTH_W'(STACK_DEPTH))
    else $error("stack full reported below capacity");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_NO_ROOM) || (out_status == ST_STACK_FULL)
      || (out_status == ST_STACK_EMPTY)) |-> (out_slot_index == '0)
      && ((out_status != ST_STACK_EMPTY) || (out_stack_depth == '0)))
    else $error("failure item carries a slot or a nonzero depth");

endmodule

bind bitmap_register_allocator_unit bra_checker #(.STACK_DEPTH(STACK_DEPTH)) u_bra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_slot_index  (out_ch.slot_index),
  .out_high_water  (out_ch.high_water),
  .out_stack_depth (out_ch.stack_depth)
);

`default_nettype wire

@@ sim/bitmap_register_allocator_unit_tb.sv @@
// Testbench for bitmap_register_allocator_unit: directed and random requests,
// with results checked against an in-bench allocator tracker.
// Depends on bra_pkg, bra_in_if / bra_out_if and the allocator RTL.

module bitmap_register_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bra_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  localparam int NW = NUM_WORDS_DEF;
  localparam int SD = STACK_DEPTH_DEF;
  localparam int MR = MAX_RUN_DEF;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  localparam int ITEM_TARGET = 1300;
  localparam int QUIET_FROM = 1150;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  // opcodes the block decodes as no-ops
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef logic [NW-1:0][WB-1:0] bitmap_t;

  typedef struct {
    status_t                 status;
    logic [SLOT_W-1:0]       slot;
    logic [HIGH_WATER_W-1:0] high_water;
    logic [DEPTH_W-1:0]      depth;
  } reply_t;

  class slot_tracker;
    bitmap_t     bitmap;
    bitmap_t     saved [SD];
    int unsigned depth;
    int unsigned mark;
    reply_t      predicted_replies [$];
    int unsigned mismatches;

    function new();
      bitmap = '0;
      depth = 0;
      mark = 0;
      mismatches = 0;
    endfunction

    function bit grant_one(output int unsigned slot);
      slot = 0;
      for (int w = 0; w < NW; w++) begin
        for (int b = 0; b < WB; b++) begin
          if (!bitmap[w][b]) begin
            bitmap[w][b] = 1'b1;
            slot = w * WB + b;
            if (slot + 1 > mark) mark = slot + 1;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function bit grant_run(int unsigned len, output int unsigned slot);
      logic [WB-1:0] run_mask;
      logic [WB-1:0] free_bits;
      slot = 0;
      if (len == 0 || len > MR || len > WB) return 1'b0;
      run_mask = '1;
      run_mask = run_mask >> (WB - len);
      for (int w = 0; w < NW; w++) begin
        free_bits = ~bitmap[w];
        // last legal start is WB - len
        for (int j = 0; j + len <= WB; j++) begin
          if (((free_bits >> j) & run_mask) == run_mask) begin
            bitmap[w] = bitmap[w] | (run_mask << j);
            slot = w * WB + j;
            if (slot + len > mark) mark = slot + len;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [RUN_LEN_W-1:0] len);
      reply_t      r;
      int unsigned slot;
      bit          ok;
      r.status = ST_OK;
      slot = 0;
      case (op)
        OP_ALLOC_ONE: begin
          ok = grant_one(slot);
          if (!ok) r.status = ST_NO_ROOM;
        end
        OP_ALLOC_RUN: begin
          ok = grant_run(len, slot);
          if (!ok) r.status = ST_NO_ROOM;
        end
        OP_SAVE: begin
          if (depth >= SD) begin
            r.status = ST_STACK_FULL;
          end else begin
            saved[depth] = bitmap;
            depth++;
          end
        end
        OP_RESTORE: begin
          if (depth == 0) begin
            r.status = ST_STACK_EMPTY;
          end else begin
            depth--;
            bitmap = saved[depth];
          end
        end
        OP_CLEAR: begin
          bitmap = '0;
          depth = 0;
          mark = 0;
        end
        default: ;
      endcase
      r.slot = slot[SLOT_W-1:0];
      r.high_water = mark[HIGH_WATER_W-1:0];
      r.depth = depth[DEPTH_W-1:0];
      predicted_replies.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                               logic [HIGH_WATER_W-1:0] high_water,
                               logic [DEPTH_W-1:0] depth_out);
      reply_t want;
      if (predicted_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result item: status %0d slot %0d hw %0d depth %0d",
                   $realtime, status, slot, high_water, depth_out);
        return;
      end
      want = predicted_replies.pop_front();
      if (status !== want.status || slot !== want.slot ||
          high_water !== want.high_water || depth_out !== want.depth) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"%0t: mismatch: got status %0d slot %0d hw %0d depth %0d, ",
                    "wanted %0d %0d %0d %0d"},
                   $realtime, status, slot, high_water, depth_out,
                   want.status, want.slot, want.high_water, want.depth);
      end
    endfunction

    function int unsigned pending();
      return predicted_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bra_in_if  in_ch();
  bra_out_if out_ch();

  bitmap_register_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  slot_tracker tracker;
  bit          quiet;
  int unsigned sent;

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [RUN_LEN_W-1:0] len);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.run_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_request(op, len);
    sent++;
    if (sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [RUN_LEN_W-1:0] random_len();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return RUN_LEN_W'($urandom_range(1, 8));
    if (pick < 9) return RUN_LEN_W'($urandom_range(9, MR));
    return RUN_LEN_W'($urandom_range(0, (1 << RUN_LEN_W) - 1));
  endfunction

  task automatic mixed_item();
    int unsigned pick;
    logic [RUN_LEN_W-1:0] junk;
    pick = $urandom_range(0, 99);
    junk = RUN_LEN_W'($urandom_range(0, (1 << RUN_LEN_W) - 1));
    if (pick < 35)      send_item(OP_ALLOC_ONE, junk);
    else if (pick < 65) send_item(OP_ALLOC_RUN, random_len());
    else if (pick < 78) send_item(OP_SAVE, junk);
    else if (pick < 91) send_item(OP_RESTORE, junk);
    else if (pick < 94) send_item(OP_CLEAR, junk);
    else                send_item(OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), junk);
  endtask

  // result side: random stall bursts, none once quiet
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_result(out_ch.status, out_ch.slot_index, out_ch.high_water,
                             out_ch.stack_depth);
      if (stall != 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    tracker = new();
    quiet = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_CLEAR;
    in_ch.run_length = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of run length, stack empty, no-op codes
    send_item(OP_ALLOC_ONE, '0);
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(MR));
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(0));
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(MR + 1));
    send_item(OP_ALLOC_RUN, '1);
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(WB - 1 - MR));  // exactly fills word 0
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(1));
    send_item(OP_RESTORE, '0);
    send_item(OP_SAVE, '1);
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(MR));
    send_item(OP_ALLOC_ONE, '1);
    send_item(OP_RESTORE, '1);
    send_item(OP_UNUSED_LO, '1);
    send_item(OPCODE_W'(OP_UNUSED_LO + 1), '0);
    send_item(OP_UNUSED_HI, RUN_LEN_W'(MR));
    send_item(OP_SAVE, '0);
    send_item(OP_SAVE, '0);
    send_item(OP_CLEAR, '1);
    send_item(OP_RESTORE, '0);
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(MR));
    send_item(OP_ALLOC_RUN, RUN_LEN_W'(MR / 2));
    drain();

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          // fill the whole bitmap with maximal runs, then hit the full case
          send_item(OP_CLEAR, random_len());
          send_item(OP_SAVE, random_len());
          repeat (NW * WB / MR + 1) send_item(OP_ALLOC_RUN, RUN_LEN_W'(MR));
          send_item(OP_ALLOC_ONE, random_len());
          send_item(OP_ALLOC_RUN, RUN_LEN_W'(1));
          send_item(OP_RESTORE, random_len());
          send_item(OP_ALLOC_ONE, random_len());
        end
        1: begin
          // push past full, then pop past empty
          repeat (SD + 2) begin
            send_item(OP_SAVE, random_len());
            if ($urandom_range(0, 4) == 0) send_item(OP_ALLOC_ONE, random_len());
          end
          repeat (SD + 3) send_item(OP_RESTORE, random_len());
        end
        2: begin
          drain();
          repeat (12) mixed_item();
        end
        default: repeat (24) mixed_item();
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
